// File: rtl/moving_color_bar_test_pattern_core_macros.svh
// Assertion macros for the color bar test pattern core
`ifndef MOVING_COLOR_BAR_TEST_PATTERN_CORE_MACROS_SVH
`define MOVING_COLOR_BAR_TEST_PATTERN_CORE_MACROS_SVH

// Check a property on every clock edge outside of reset
`define MCB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define MCB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/mcb_pkg.sv
// Shared types, constants and helper functions for the color bar pattern core
`default_nettype none
package mcb_pkg;

  localparam int DIM_W   = 14;
  localparam int COORD_W = 13;
  localparam int FRAME_W = 64;
  localparam int CFG_W   = 14;
  localparam int IDX_W   = 2;
  localparam int PIX_W   = 8;
  localparam int DIV_STAGES = 8;
  localparam int DIV_BITS   = FRAME_W / DIV_STAGES;
  // Largest accepted frame dimension; larger writes saturate to it
  localparam int MAX_DIM = 8192;

  typedef enum logic [IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_CAMERA_ID    = 2'd2,
    REG_UNUSED       = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
  } rgb_t;

  // One restoring step: shift in a bit, subtract the divisor if it fits
  function automatic logic [DIM_W-1:0] mod_step(input logic [DIM_W-1:0] r,
                                                input logic            b,
                                                input logic [DIM_W-1:0] d);
    logic [DIM_W:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) t = t - {1'b0, d};
    return t[DIM_W-1:0];
  endfunction

  function automatic rgb_t bar_color(input logic [2:0] bar);
    rgb_t c;
    case (bar)
      3'd0:    c = '{8'hFF, 8'hFF, 8'hFF};
      3'd1:    c = '{8'hFF, 8'hFF, 8'h00};
      3'd2:    c = '{8'h00, 8'hFF, 8'hFF};
      3'd3:    c = '{8'h00, 8'hFF, 8'h00};
      3'd4:    c = '{8'hFF, 8'h00, 8'hFF};
      3'd5:    c = '{8'hFF, 8'h00, 8'h00};
      3'd6:    c = '{8'h00, 8'h00, 8'hFF};
      default: c = '{8'h00, 8'h00, 8'h00};
    endcase
    return c;
  endfunction

  localparam rgb_t MARKER_COLOR = '{8'd255, 8'd96, 8'd32};

endpackage
`default_nettype wire

// File: rtl/moving_color_bar_test_pattern_core.sv
// Top level of the moving color bar test pattern core
//
// Usage:
//   Input channel (in_valid / in_stall) carries one pixel transaction: column,
//   row and a 64-bit frame number. Output channel (out_valid / out_stall)
//   returns that pixel's RGB color together with Y, Cb and Cr.
//   Config port writes frame_width, frame_height and camera_id; write it only
//   while no transaction is in flight.
// Pipeline: 14 register stages from input accept to output valid.
// Throughput: one pixel per clock when not stalled; the frame-number
//   modulo runs as a pipelined restoring divider, eight bits per stage
//   over eight stages, and the bar position takes two more reduction stages.
// Reset: synchronous rst_n low clears all valid bits and loads
//   640 x 480 with the marker off.
// Stall: when out_stall holds a valid result, the whole pipeline freezes and
//   in_stall rises in the same cycle; nothing is dropped or repeated.
`default_nettype none
module moving_color_bar_test_pattern_core
  import mcb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [COORD_W-1:0]   in_pixel_x,
  input  wire logic [COORD_W-1:0]   in_pixel_y,
  input  wire logic [FRAME_W-1:0]   in_frame_number,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [PIX_W-1:0]          out_red,
  output logic [PIX_W-1:0]          out_green,
  output logic [PIX_W-1:0]          out_blue,
  output logic [PIX_W-1:0]          out_luma,
  output logic [PIX_W-1:0]          out_chroma_blue,
  output logic [PIX_W-1:0]          out_chroma_red
);

  // ---------------- configuration registers ----------------
  logic [DIM_W-1:0] width_r, height_r, band_r;
  logic [7:0]       cam_r;
  logic [DIM_W-1:0] dim_sat;
  logic [27:0]      band_prod;

  // Saturate oversized dimensions to MAX_DIM
  always_comb begin
    if ({18'd0, cfg_wdata} > 32'(MAX_DIM)) dim_sat = DIM_W'(MAX_DIM);
    else dim_sat = cfg_wdata;
    // height/12 as (height/4)/3 by reciprocal multiply, exact below 2^16
    band_prod = {16'd0, dim_sat[DIM_W-1:2]} * 28'd43691;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(640);
      height_r <= DIM_W'(480);
      band_r   <= DIM_W'(40);
      cam_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  width_r <= dim_sat;
        REG_FRAME_HEIGHT: begin
          height_r <= dim_sat;
          band_r   <= DIM_W'(band_prod[27:17]);
        end
        REG_CAMERA_ID:    cam_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  // Advance everything unless the output register holds a stalled result
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  logic [DIM_W-1:0] band_min;
  assign band_min = (band_r == '0) ? DIM_W'(1) : band_r;

  // ---------------- stage 0 and divider stages ----------------
  // Index 0 is the input register; 1..8 each fold eight bits of 3x and 2x the
  // frame number into the remainders mod width (scroll) and mod height (band top).
  logic                 dv_r  [0:DIV_STAGES];
  logic [COORD_W-1:0]   dx_r  [0:DIV_STAGES];
  logic [COORD_W-1:0]   dy_r  [0:DIV_STAGES];
  logic [PIX_W-1:0]     dg_r  [0:DIV_STAGES];
  logic [FRAME_W-1:0]   df3_r [0:DIV_STAGES];
  logic [FRAME_W-1:0]   df2_r [0:DIV_STAGES];
  logic [DIM_W-1:0]     rw_r  [0:DIV_STAGES];
  logic [DIM_W-1:0]     rh_r  [0:DIV_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r[0] <= 1'b0;
    else if (en) dv_r[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r[0]  <= in_pixel_x;
      dy_r[0]  <= in_pixel_y;
      dg_r[0]  <= in_pixel_x[PIX_W-1:0] + in_frame_number[PIX_W-1:0];
      df3_r[0] <= in_frame_number + {in_frame_number[FRAME_W-2:0], 1'b0};
      df2_r[0] <= {in_frame_number[FRAME_W-2:0], 1'b0};
      rw_r[0]  <= '0;
      rh_r[0]  <= '0;
    end
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic [DIM_W-1:0] rw_nxt, rh_nxt;

    always_comb begin
      rw_nxt = rw_r[k];
      rh_nxt = rh_r[k];
      for (int i = 0; i < DIV_BITS; i++) begin
        rw_nxt = mod_step(rw_nxt, df3_r[k][FRAME_W-1-k*DIV_BITS-i], width_r);
        rh_nxt = mod_step(rh_nxt, df2_r[k][FRAME_W-1-k*DIV_BITS-i], height_r);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[k+1] <= 1'b0;
      else if (en) dv_r[k+1] <= dv_r[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dx_r[k+1]  <= dx_r[k];
        dy_r[k+1]  <= dy_r[k];
        dg_r[k+1]  <= dg_r[k];
        df3_r[k+1] <= df3_r[k];
        df2_r[k+1] <= df2_r[k];
        rw_r[k+1]  <= rw_nxt;
        rh_r[k+1]  <= rh_nxt;
      end
    end
  end

  // ---------------- E1: band test, upper half of (x + scroll) mod width ----
  logic [DIM_W:0]   e1_sum;
  logic [DIM_W-1:0] e1_r_nxt;
  logic [DIM_W:0]   e1_end;
  logic             e1_band;

  always_comb begin
    e1_sum = {2'b00, dx_r[DIV_STAGES]} + {1'b0, rw_r[DIV_STAGES]};
    e1_r_nxt = '0;
    for (int i = DIM_W; i >= 7; i--) begin
      e1_r_nxt = mod_step(e1_r_nxt, e1_sum[i], width_r);
    end
    e1_end  = {1'b0, rh_r[DIV_STAGES]} + {1'b0, band_min};
    e1_band = (height_r != '0) &&
              ({1'b0, dy_r[DIV_STAGES]} >= rh_r[DIV_STAGES]) &&
              ({2'b00, dy_r[DIV_STAGES]} < e1_end) &&
              ({1'b0, dy_r[DIV_STAGES]} < height_r);
  end

  logic             e1_v_r;
  logic [6:0]       e1_lo_r;
  logic [DIM_W-1:0] e1_rem_r;
  logic [COORD_W-1:0] e1_x_r;
  logic [PIX_W-1:0] e1_g_r;
  logic             e1_band_r;

  always_ff @(posedge clk) begin
    if (!rst_n) e1_v_r <= 1'b0;
    else if (en) e1_v_r <= dv_r[DIV_STAGES];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_lo_r   <= e1_sum[6:0];
      e1_rem_r  <= e1_r_nxt;
      e1_x_r    <= dx_r[DIV_STAGES];
      e1_g_r    <= dg_r[DIV_STAGES];
      e1_band_r <= e1_band;
    end
  end

  // ---------------- E2: lower half of the reduction ----------------
  logic [DIM_W-1:0] e2_r_nxt;

  always_comb begin
    e2_r_nxt = e1_rem_r;
    for (int i = 6; i >= 0; i--) begin
      e2_r_nxt = mod_step(e2_r_nxt, e1_lo_r[i], width_r);
    end
  end

  logic             e2_v_r;
  logic [DIM_W-1:0] e2_shift_r;
  logic [COORD_W-1:0] e2_x_r;
  logic [PIX_W-1:0] e2_g_r;
  logic             e2_band_r;

  always_ff @(posedge clk) begin
    if (!rst_n) e2_v_r <= 1'b0;
    else if (en) e2_v_r <= e1_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e2_shift_r <= e2_r_nxt;
      e2_x_r     <= e1_x_r;
      e2_g_r     <= e1_g_r;
      e2_band_r  <= e1_band_r;
    end
  end

  // ---------------- E3: bar index, color select, overlays ----------------
  logic [2:0]       e3_bar;
  logic [DIM_W:0]   e3_t;
  logic [DIM_W-1:0] e3_rem;
  rgb_t             e3_color;

  always_comb begin
    // Three quotient bits of shifted*8/width; shifted < width keeps it below 8
    e3_rem = e2_shift_r;
    e3_bar = '0;
    for (int i = 2; i >= 0; i--) begin
      e3_t = {e3_rem, 1'b0};
      if (e3_t >= {1'b0, width_r}) begin
        e3_t      = e3_t - {1'b0, width_r};
        e3_bar[i] = 1'b1;
      end
      e3_rem = e3_t[DIM_W-1:0];
    end
    if (width_r == '0) e3_bar = '0;

    e3_color = bar_color(e3_bar);
    if (e2_band_r) e3_color = '{e2_g_r, e2_g_r, e2_g_r};
    if ((cam_r == 8'd1) && ({1'b0, e2_x_r} < (width_r >> 4)))
      e3_color = MARKER_COLOR;
  end

  logic e3_v_r;
  rgb_t e3_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) e3_v_r <= 1'b0;
    else if (en) e3_v_r <= e2_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) e3_c_r <= e3_color;
  end

  // ---------------- E4: weighted sums ----------------
  logic        [15:0] e4_y;
  logic signed [16:0] e4_cb, e4_cr;
  logic signed [16:0] rs, gs, bs;

  always_comb begin
    rs    = 17'(e3_c_r.r);
    gs    = 17'(e3_c_r.g);
    bs    = 17'(e3_c_r.b);
    e4_y  = 16'(16'd77 * e3_c_r.r) + 16'(16'd150 * e3_c_r.g) + 16'(16'd29 * e3_c_r.b);
    e4_cb = -(17'sd43 * rs) - (17'sd85 * gs) + (17'sd128 * bs);
    e4_cr = (17'sd128 * rs) - (17'sd107 * gs) - (17'sd21 * bs);
  end

  logic               e4_v_r;
  rgb_t               e4_c_r;
  logic        [15:0] e4_y_r;
  logic signed [16:0] e4_cb_r, e4_cr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) e4_v_r <= 1'b0;
    else if (en) e4_v_r <= e3_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e4_c_r  <= e3_c_r;
      e4_y_r  <= e4_y;
      e4_cb_r <= e4_cb;
      e4_cr_r <= e4_cr;
    end
  end

  // ---------------- output register: shift, offset, clamp ----------------
  logic signed [9:0] cb_off, cr_off;
  logic [PIX_W-1:0]  cb_clamp, cr_clamp;

  always_comb begin
    // Arithmetic shift floors toward minus infinity
    cb_off = 10'(e4_cb_r >>> 8) + 10'sd128;
    cr_off = 10'(e4_cr_r >>> 8) + 10'sd128;
    if (cb_off < 0) cb_clamp = '0;
    else if (cb_off > 10'sd255) cb_clamp = 8'hFF;
    else cb_clamp = cb_off[7:0];
    if (cr_off < 0) cr_clamp = '0;
    else if (cr_off > 10'sd255) cr_clamp = 8'hFF;
    else cr_clamp = cr_off[7:0];
  end

  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= e4_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_red         <= e4_c_r.r;
      out_green       <= e4_c_r.g;
      out_blue        <= e4_c_r.b;
      out_luma        <= e4_y_r[15:8];
      out_chroma_blue <= cb_clamp;
      out_chroma_red  <= cr_clamp;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// File: rtl/mcb_checker.sv
// Port-level checker for the color bar pattern core, bound to the top level
`default_nettype none
`include "moving_color_bar_test_pattern_core_macros.svh"
module mcb_checker
  import mcb_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_stall,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [PIX_W-1:0] out_red,
  input wire logic [PIX_W-1:0] out_green,
  input wire logic [PIX_W-1:0] out_blue,
  input wire logic [PIX_W-1:0] out_chroma_blue,
  input wire logic [PIX_W-1:0] out_chroma_red
);

  `MCB_ASSERT_ALWAYS(a_no_valid_after_reset, !rst_n |=> !out_valid, "valid after reset")
  `MCB_ASSERT(a_stall_only_on_backpressure, in_stall |-> (out_valid && out_stall), "needless stall")
  `MCB_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(out_red)), "out dropped")
  `MCB_ASSERT(a_gray_neutral, (out_valid && out_red == out_green && out_green == out_blue) |-> (out_chroma_blue == 8'd128 && out_chroma_red == 8'd128), "gray chroma off")

endmodule

bind moving_color_bar_test_pattern_core mcb_checker u_mcb_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_red         (out_red),
  .out_green       (out_green),
  .out_blue        (out_blue),
  .out_chroma_blue (out_chroma_blue),
  .out_chroma_red  (out_chroma_red)
);
`default_nettype wire
